// ===== sv/mrlp_pkg.sv =====
package mrlp_pkg;

    localparam int ValueBitsDef = 64;
    localparam int MaxPos       = 64;
    localparam int QueueDepth   = 2;

    typedef enum logic [1:0] {
        KIND_DEC = 2'd0,
        KIND_HEX = 2'd1,
        KIND_BIN = 2'd2,
        KIND_CHR = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_LITTLE_ENDIAN = 1'b0,
        CFG_SHOW_ALL      = 1'b1
    } t_cfg_index;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // Hex digit value with a valid flag in bit 4.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end else if (c >= CH_LA && c <= CH_LF) begin
            d = c - CH_LA + 8'd10;
            return {1'b1, d[3:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

// ===== sv/mrlp_front.sv =====
module mrlp_front #(
    parameter int VALUE_BITS = mrlp_pkg::ValueBitsDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [7:0]                  i_chr,
    input  logic                        i_final_req,
    output logic                        o_push,
    output logic [4*VALUE_BITS+6:0]     o_rec
);
    import mrlp_pkg::*;

    localparam int VB = VALUE_BITS;

    logic [VB-1:0] r_dec_acc, n_dec_acc, r_dec_w, n_dec_w;
    logic [VB-1:0] r_hex_acc, n_hex_acc;
    logic [VB-1:0] r_bin_acc, n_bin_acc;
    logic [VB-1:0] r_chr_acc, n_chr_acc;
    logic [6:0]    r_hex_pos, n_hex_pos;
    logic [6:0]    r_bin_pos, n_bin_pos;
    logic [6:0]    r_chr_pos, n_chr_pos;
    logic          r_hex_pfx, n_hex_pfx;
    logic [2:0]    r_sign, n_sign;
    logic [3:0]    r_alive, n_alive;

    logic [4:0]    hex_d;
    logic [7:0]    dec_d;
    logic [VB-1:0] dec_prod;

    assign hex_d    = hex_val(i_chr);
    assign dec_d    = i_chr - CH_ZERO;
    assign dec_prod = r_dec_w * VB'(dec_d[3:0]);

    always_comb begin
        n_dec_acc = r_dec_acc;
        n_dec_w   = r_dec_w;
        n_hex_acc = r_hex_acc;
        n_bin_acc = r_bin_acc;
        n_chr_acc = r_chr_acc;
        n_hex_pos = r_hex_pos;
        n_bin_pos = r_bin_pos;
        n_chr_pos = r_chr_pos;
        n_hex_pfx = r_hex_pfx;
        n_sign    = r_sign;
        n_alive   = r_alive;

        if (r_alive[0]) begin
            if (i_chr == CH_MINUS) begin
                n_dec_acc = VB'(0) - r_dec_acc;
                n_sign[0] = ~r_sign[0];
            end else if (i_chr == CH_PLUS) begin
                n_dec_acc = r_dec_acc;
            end else if (i_chr >= CH_ZERO && i_chr <= CH_NINE) begin
                n_dec_acc = r_dec_acc + dec_prod;
                n_dec_w   = (r_dec_w << 3) + (r_dec_w << 1);
            end else begin
                n_alive[0] = 1'b0;
            end
        end

        if (r_alive[1]) begin
            if (i_chr == CH_MINUS) begin
                n_hex_acc = VB'(0) - r_hex_acc;
                n_sign[1] = ~r_sign[1];
                n_hex_pfx = 1'b1;
            end else if (i_chr == CH_PLUS || i_chr == CH_X) begin
                n_hex_pfx = 1'b1;
            end else if (r_hex_pfx) begin
                n_hex_pfx = 1'b1;
            end else if (hex_d[4]) begin
                if (r_hex_pos < 7'(VB)) begin
                    n_hex_acc = r_hex_acc + (VB'(hex_d[3:0]) << r_hex_pos);
                end
                if (r_hex_pos < 7'(MaxPos)) begin
                    n_hex_pos = r_hex_pos + 7'd4;
                end
            end else begin
                n_alive[1] = 1'b0;
            end
        end

        if (r_alive[2]) begin
            if (i_chr == CH_ZERO || i_chr == CH_ONE) begin
                if (r_bin_pos < 7'(VB)) begin
                    n_bin_acc = r_bin_acc + (VB'(i_chr[0]) << r_bin_pos);
                end
                if (r_bin_pos < 7'(MaxPos)) begin
                    n_bin_pos = r_bin_pos + 7'd1;
                end
            end else if (i_chr == CH_PCT) begin
                n_bin_acc = r_bin_acc;
            end else if (i_chr == CH_MINUS) begin
                n_bin_acc = VB'(0) - r_bin_acc;
                n_sign[2] = ~r_sign[2];
            end else begin
                n_alive[2] = 1'b0;
            end
        end

        if (r_alive[3]) begin
            if (i_chr != CH_DQUOT && i_chr != CH_SQUOT && r_chr_pos < 7'(VB)) begin
                n_chr_acc = r_chr_acc + (VB'(i_chr) << r_chr_pos);
                n_chr_pos = r_chr_pos + 7'd8;
            end
        end
    end

    assign o_push = i_accept && i_final_req;
    assign o_rec  = {n_alive, n_sign, n_chr_acc, n_bin_acc, n_hex_acc, n_dec_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_final_req)) begin
            r_dec_acc <= '0;
            r_dec_w   <= VB'(1);
            r_hex_acc <= '0;
            r_bin_acc <= '0;
            r_chr_acc <= '0;
            r_hex_pos <= '0;
            r_bin_pos <= '0;
            r_chr_pos <= '0;
            r_hex_pfx <= 1'b0;
            r_sign    <= '0;
            r_alive   <= '1;
        end else if (i_accept) begin
            r_dec_acc <= n_dec_acc;
            r_dec_w   <= n_dec_w;
            r_hex_acc <= n_hex_acc;
            r_bin_acc <= n_bin_acc;
            r_chr_acc <= n_chr_acc;
            r_hex_pos <= n_hex_pos;
            r_bin_pos <= n_bin_pos;
            r_chr_pos <= n_chr_pos;
            r_hex_pfx <= n_hex_pfx;
            r_sign    <= n_sign;
            r_alive   <= n_alive;
        end
    end

endmodule

// ===== sv/mrlp_queue.sv =====
module mrlp_queue #(
    parameter int WIDTH = 263,
    parameter int DEPTH = mrlp_pkg::QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_cnt == $past(r_cnt) - CW'(1)))
        else $error("queue count did not drop on pop");

endmodule

// ===== sv/mrlp_back.sv =====
module mrlp_back #(
    parameter int VALUE_BITS = mrlp_pkg::ValueBitsDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_little_endian,
    input  logic                     i_show_all,
    input  logic                     i_q_valid,
    input  logic [4*VALUE_BITS+6:0]  i_q_data,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output mrlp_pkg::t_kind          o_kind,
    output logic [63:0]              o_value,
    output logic [3:0]               o_byte_count,
    output logic                     o_negative,
    output logic                     o_no_match,
    output logic                     o_last
);
    import mrlp_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam logic [63:0] VMASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VB);

    // queue head fields
    logic [VB-1:0] h_dec, h_hex, h_bin, h_chr;
    logic [2:0]    h_sign;
    logic [3:0]    h_alive;

    assign h_dec   = i_q_data[VB-1:0];
    assign h_hex   = i_q_data[2*VB-1:VB];
    assign h_bin   = i_q_data[3*VB-1:2*VB];
    assign h_chr   = i_q_data[4*VB-1:3*VB];
    assign h_sign  = i_q_data[4*VB+2:4*VB];
    assign h_alive = i_q_data[4*VB+6:4*VB+3];

    logic          s1_free, s2_free, out_free;
    logic          load;
    logic [3:0]    r_done;
    logic [3:0]    first_alive, list, pending, sel;
    logic          sel_last, sel_nm, sel_neg;
    t_kind         sel_kind;
    logic [VB-1:0] sel_acc;

    // stage 1: chosen reading
    logic          r1_valid, r1_neg, r1_last, r1_nm;
    t_kind         r1_kind;
    logic [VB-1:0] r1_acc;

    // stage 2: byte count known
    logic          r2_valid, r2_neg, r2_last, r2_nm;
    t_kind         r2_kind;
    logic [VB-1:0] r2_acc;
    logic [3:0]    r2_n;

    logic [VB-1:0] mag;
    logic [63:0]   mag64;
    logic [3:0]    cnt_n;
    logic [63:0]   acc64, fmt_v, neg_mask;

    assign out_free = !o_valid || !i_stall;
    assign s2_free  = !r2_valid || out_free;
    assign s1_free  = !r1_valid || s2_free;

    // walk the head literal's live readers, one per cycle unless stalled
    assign first_alive = h_alive & (~h_alive + 4'd1);
    assign list        = i_show_all ? h_alive : first_alive;
    assign pending     = list & ~r_done;
    assign sel         = pending & (~pending + 4'd1);
    assign sel_last    = ((pending & ~sel) == 4'd0);
    assign sel_nm      = (h_alive == 4'd0);
    assign load        = i_q_valid && s1_free;
    assign o_pop       = load && sel_last;

    always_comb begin
        sel_kind = KIND_DEC;
        sel_acc  = h_dec;
        sel_neg  = h_sign[0];
        if (sel[1]) begin
            sel_kind = KIND_HEX;
            sel_acc  = h_hex;
            sel_neg  = h_sign[1];
        end else if (sel[2]) begin
            sel_kind = KIND_BIN;
            sel_acc  = h_bin;
            sel_neg  = h_sign[2];
        end else if (sel[3]) begin
            sel_kind = KIND_CHR;
            sel_acc  = h_chr;
            sel_neg  = 1'b0;
        end else if (sel_nm) begin
            sel_neg  = 1'b0;
        end
    end

    // byte count of the magnitude, rounded up to even in little-endian mode
    always_comb begin
        mag   = r1_neg ? (VB'(0) - r1_acc) : r1_acc;
        mag64 = 64'(mag);
        cnt_n = 4'd1;
        for (int i = 1; i < 8; i++) begin
            if (mag64[8*i +: 8] != 8'd0) begin
                cnt_n = 4'(i + 1);
            end
        end
        if (i_little_endian && cnt_n[0]) begin
            cnt_n = cnt_n + 4'd1;
        end
    end

    // byte reversal in little-endian mode, negative trim and width mask
    always_comb begin
        logic [2:0] src;
        src   = 3'd0;
        acc64 = 64'(r2_acc);
        fmt_v = acc64;
        if (i_little_endian) begin
            fmt_v = '0;
            for (int i = 0; i < 8; i++) begin
                if (4'(i) < r2_n) begin
                    src = 3'(r2_n - 4'(i) - 4'd1);
                    fmt_v[8*i +: 8] = acc64[8*src +: 8];
                end
            end
        end
        neg_mask = (r2_n == 4'd8) ? 64'hFFFF_FFFF_FFFF_FFFF
                                  : ((64'd1 << {r2_n, 3'b000}) - 64'd1);
        if (r2_neg) begin
            fmt_v = fmt_v & neg_mask;
        end
        fmt_v = fmt_v & VMASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_done <= '0;
            end else if (load) begin
                r_done <= r_done | sel;
            end
            if (s1_free) begin
                r1_valid <= i_q_valid;
            end
            if (s2_free) begin
                r2_valid <= r1_valid;
            end
            if (out_free) begin
                o_valid <= r2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r1_kind <= sel_kind;
            r1_acc  <= sel_acc;
            r1_neg  <= sel_neg;
            r1_last <= sel_last;
            r1_nm   <= sel_nm;
        end
        if (s2_free && r1_valid) begin
            r2_kind <= r1_kind;
            r2_acc  <= r1_acc;
            r2_neg  <= r1_neg;
            r2_last <= r1_last;
            r2_nm   <= r1_nm;
            r2_n    <= cnt_n;
        end
        if (out_free && r2_valid) begin
            o_last     <= r2_last;
            o_no_match <= r2_nm;
            if (r2_nm) begin
                o_kind       <= KIND_DEC;
                o_value      <= '0;
                o_byte_count <= '0;
                o_negative   <= 1'b0;
            end else begin
                o_kind       <= r2_kind;
                o_value      <= fmt_v;
                o_byte_count <= r2_n;
                o_negative   <= r2_neg;
            end
        end
    end

endmodule

// ===== sv/multi_radix_literal_parser.sv =====
// Multi-radix literal parser. Feed the characters of one literal last to first, one request
// per cycle; mark the literal's first character with i_final_req. Decimal, hex, binary and
// packed-character readers update in parallel on every character, so the input side takes one
// character per clock while o_stall is low. On the final character the reader state is pushed
// into a two-entry queue and the output side emits one result per clock while i_stall is low:
// one per literal, or up to four when show_all is set. A literal that yields several results
// occupies the output side until all of them are emitted; o_stall rises only when the queue is
// full. Write configuration only while no literal is in flight.
module multi_radix_literal_parser #(
    parameter int VALUE_BITS = mrlp_pkg::ValueBitsDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_chr,
    input  logic            i_final_req,
    output logic            o_valid,
    input  logic            i_stall,
    output mrlp_pkg::t_kind o_kind,
    output logic [63:0]     o_value,
    output logic [3:0]      o_byte_count,
    output logic            o_negative,
    output logic            o_no_match,
    output logic            o_last,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic            i_cfg_data
);
    import mrlp_pkg::*;

    localparam int RecW = 4 * VALUE_BITS + 7;

    logic            r_little_endian, r_show_all;
    logic            accept, push, q_full, q_valid, pop;
    logic [RecW-1:0] rec, q_data;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !o_stall;
    assign o_stall     = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_little_endian <= 1'b0;
            r_show_all      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LITTLE_ENDIAN: r_little_endian <= i_cfg_data;
                CFG_SHOW_ALL:      r_show_all      <= i_cfg_data;
                default:           r_show_all      <= r_show_all;
            endcase
        end
    end

    mrlp_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_chr       (i_chr),
        .i_final_req (i_final_req),
        .o_push      (push),
        .o_rec       (rec)
    );

    mrlp_queue #(
        .WIDTH(RecW),
        .DEPTH(QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    mrlp_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_little_endian (r_little_endian),
        .i_show_all      (r_show_all),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_value         (o_value),
        .o_byte_count    (o_byte_count),
        .o_negative      (o_negative),
        .o_no_match      (o_no_match),
        .o_last          (o_last)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mrlp_pkg::*;

    localparam int VB = ValueBitsDef;
    localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - VB);
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [3:0]  byte_count;
        logic        negative;
        logic        no_match;
        logic        last;
    } t_reading;

    typedef enum int {
        LIT_DEC,
        LIT_HEX,
        LIT_BIN,
        LIT_CHR,
        LIT_NOISE
    } t_lit_form;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_chr;
    logic        i_final_req;
    logic        o_valid;
    logic        i_stall;
    t_kind       o_kind;
    logic [63:0] o_value;
    logic [3:0]  o_byte_count;
    logic        o_negative;
    logic        o_no_match;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index;
    logic        i_cfg_data;

    multi_radix_literal_parser uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_chr        (i_chr),
        .i_final_req  (i_final_req),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_byte_count (o_byte_count),
        .o_negative   (o_negative),
        .o_no_match   (o_no_match),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state for the literal being read.
    logic [63:0] dec_sum, dec_scale, hex_sum, bin_sum, chr_sum;
    int          hex_shift, bin_shift, chr_shift;
    logic        hex_pfx;
    logic [2:0]  neg_flags;
    logic [3:0]  live;
    logic        cfg_le = 1'b0;
    logic        cfg_all = 1'b0;

    t_reading    pending_readings[$];
    logic [7:0]  lit_chars[$];
    int          mismatch_cnt = 0;
    int          chars_sent = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    logic        pace_on = 1'b0;

    task automatic clear_parse();
        dec_sum = '0; dec_scale = 64'd1;
        hex_sum = '0; hex_shift = 0; hex_pfx = 1'b0;
        bin_sum = '0; bin_shift = 0;
        chr_sum = '0; chr_shift = 0;
        neg_flags = '0; live = 4'hF;
    endtask

    function automatic logic [3:0] bytes_used(logic [63:0] v, logic neg);
        logic [63:0] x;
        logic [3:0]  n;
        x = (neg ? -v : v) & VMASK;
        n = 4'd1;
        for (int i = 1; i < 8; i++) begin
            if (x[8*i +: 8] != 8'd0) n = 4'(i + 1);
        end
        return n;
    endfunction

    function automatic t_reading make_reading(t_kind kind, logic [63:0] acc, logic neg);
        t_reading    r;
        int          nb;
        logic [63:0] v;
        nb = int'(bytes_used(acc, neg));
        v = acc;
        if (cfg_le) begin
            if (nb % 2 == 1) nb++;
            v = '0;
            for (int i = 0; i < nb; i++) v[8*i +: 8] = acc[8*(nb-1-i) +: 8];
        end
        if (neg) v &= {64{1'b1}} >> (64 - 8*nb);
        r.kind = kind;
        r.value = v & VMASK;
        r.byte_count = 4'(nb);
        r.negative = neg;
        r.no_match = 1'b0;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic parse_char(input logic [7:0] c, input logic fin);
        logic [4:0] hd;
        t_reading   outs[4];
        int         cnt;
        cnt = 0;
        hd = 5'd16;
        if (c >= CH_ZERO && c <= CH_NINE) hd = 5'(c - CH_ZERO);
        else if (c >= CH_LA && c <= CH_LF) hd = 5'(c - CH_LA + 8'd10);
        else if (c >= CH_UA && c <= CH_UF) hd = 5'(c - CH_UA + 8'd10);

        if (live[0]) begin
            if (c == CH_MINUS) begin
                dec_sum = -dec_sum & VMASK;
                neg_flags[0] = ~neg_flags[0];
            end else if (c == CH_PLUS) begin
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                dec_sum = (dec_sum + {56'd0, c - CH_ZERO} * dec_scale) & VMASK;
                dec_scale = (dec_scale * 64'd10) & VMASK;
            end else begin
                live[0] = 1'b0;
            end
        end
        if (live[1]) begin
            if (c == CH_MINUS) begin
                hex_sum = -hex_sum & VMASK;
                neg_flags[1] = ~neg_flags[1];
                hex_pfx = 1'b1;
            end else if (c == CH_PLUS || c == CH_X) begin
                hex_pfx = 1'b1;
            end else if (hex_pfx) begin
            end else if (hd < 5'd16) begin
                if (hex_shift < VB) hex_sum = (hex_sum + ({60'd0, hd[3:0]} << hex_shift)) & VMASK;
                if (hex_shift < 64) hex_shift += 4;
            end else begin
                live[1] = 1'b0;
            end
        end
        if (live[2]) begin
            if (c == CH_ZERO || c == CH_ONE) begin
                if (bin_shift < VB) bin_sum = (bin_sum + ({63'd0, c[0]} << bin_shift)) & VMASK;
                if (bin_shift < 64) bin_shift++;
            end else if (c == CH_PCT) begin
            end else if (c == CH_MINUS) begin
                bin_sum = -bin_sum & VMASK;
                neg_flags[2] = ~neg_flags[2];
            end else begin
                live[2] = 1'b0;
            end
        end
        if (live[3]) begin
            if (c == CH_DQUOT || c == CH_SQUOT) begin
            end else if (chr_shift < VB) begin
                chr_sum = (chr_sum + ({56'd0, c} << chr_shift)) & VMASK;
                chr_shift += 8;
            end
        end

        if (fin) begin
            if (live[0]) begin
                outs[cnt] = make_reading(KIND_DEC, dec_sum, neg_flags[0]);
                cnt++;
            end
            if (live[1] && (cnt == 0 || cfg_all)) begin
                outs[cnt] = make_reading(KIND_HEX, hex_sum, neg_flags[1]);
                cnt++;
            end
            if (live[2] && (cnt == 0 || cfg_all)) begin
                outs[cnt] = make_reading(KIND_BIN, bin_sum, neg_flags[2]);
                cnt++;
            end
            if (live[3] && (cnt == 0 || cfg_all)) begin
                outs[cnt] = make_reading(KIND_CHR, chr_sum, 1'b0);
                cnt++;
            end
            if (cnt == 0) begin
                outs[0] = '0;
                outs[0].kind = KIND_DEC;
                outs[0].no_match = 1'b1;
                cnt = 1;
            end
            outs[cnt-1].last = 1'b1;
            for (int i = 0; i < cnt; i++) pending_readings.push_back(outs[i]);
            clear_parse();
        end
    endtask

    initial clear_parse();

    // Predict on every accepted character.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) parse_char(i_chr, i_final_req);
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_readings.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected result: kind %0d value %h bytes %0d",
                             o_kind, o_value, o_byte_count);
                mismatch_cnt++;
            end else begin
                want = pending_readings.pop_front();
                if (o_kind != want.kind || o_value != want.value ||
                    o_byte_count != want.byte_count || o_negative != want.negative ||
                    o_no_match != want.no_match || o_last != want.last) begin
                    if (mismatch_cnt < 10) begin
                        $write("result mismatch (exp/got): kind %0d/%0d value %h/%h ",
                               want.kind, o_kind, want.value, o_value);
                        $display("bytes %0d/%0d neg %b/%b no_match %b/%b last %b/%b",
                                 want.byte_count, o_byte_count, want.negative, o_negative,
                                 want.no_match, o_no_match, want.last, o_last);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // Receiver back-pressure: switch between free, random and periodic stalls.
    initial begin
        int stall_mode;
        int stall_len;
        int stall_tick;
        i_stall = 1'b0;
        stall_tick = 0;
        forever begin
            stall_mode = $urandom_range(0, 2);
            stall_len = $urandom_range(40, 200);
            repeat (stall_len) begin
                @(negedge i_clk);
                stall_tick++;
                case (stall_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 2) == 0);
                    default: i_stall <= (stall_tick % 7 < 3);
                endcase
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        if (pace_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        i_valid <= 1'b1;
        i_chr <= c;
        i_final_req <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        chars_sent++;
        @(negedge i_clk);
    endtask

    // Feed the literal last character first; its first character closes the request stream.
    task automatic send_literal();
        for (int i = lit_chars.size() - 1; i >= 0; i--) send_char(lit_chars[i], i == 0);
    endtask

    task automatic send_text(input string s);
        lit_chars = {};
        for (int i = 0; i < s.len(); i++) lit_chars.push_back(s[i]);
        send_literal();
    endtask

    function automatic logic [7:0] rand_hex_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
    endfunction

    task automatic build_literal(input t_lit_form form, input int len);
        int sel;
        lit_chars = {};
        case (form)
            LIT_DEC: begin
                sel = $urandom_range(0, 3);
                if (sel == 1 || sel == 3) lit_chars.push_back(CH_MINUS);
                if (sel == 3) lit_chars.push_back(CH_MINUS);
                if (sel == 2) lit_chars.push_back(CH_PLUS);
                repeat (len) lit_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            LIT_HEX: begin
                if ($urandom_range(0, 1)) lit_chars.push_back(CH_MINUS);
                if ($urandom_range(0, 3) != 0) begin
                    lit_chars.push_back(CH_ZERO);
                    lit_chars.push_back(CH_X);
                end
                repeat (len) lit_chars.push_back(rand_hex_digit());
            end
            LIT_BIN: begin
                if ($urandom_range(0, 1)) lit_chars.push_back(CH_MINUS);
                if ($urandom_range(0, 3) != 0) lit_chars.push_back(CH_PCT);
                repeat (len) lit_chars.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
            end
            LIT_CHR: begin
                lit_chars.push_back($urandom_range(0, 1) ? CH_SQUOT : CH_DQUOT);
                repeat (len) lit_chars.push_back(8'($urandom_range(0, 255)));
                lit_chars.push_back($urandom_range(0, 1) ? CH_SQUOT : CH_DQUOT);
            end
            default: begin
                repeat (len) lit_chars.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        // Let a literal with no result so far clear the pipeline.
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apply_mode(input logic le, input logic all);
        wait_drained();
        for (int r = 0; r < 2; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (r == 0) ? CFG_LITTLE_ENDIAN : CFG_SHOW_ALL;
            i_cfg_data <= (r == 0) ? le : all;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            if (r == 0) cfg_le = le;
            else cfg_all = all;
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        pace_on = 1'b0;
        send_text("-12");
        send_text("0xFf");
        send_text("%101");
        send_text("'AB\"");
        send_text("+9");
        // Minus acts as hex prefix and negation; 'x' ends dec and bin.
        send_text("x-1");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_wide_shifts();
        pace_on = 1'b1;
        build_literal(LIT_HEX, 17);
        send_literal();
        build_literal(LIT_CHR, 10);
        send_literal();
        build_literal(LIT_DEC, 21);
        send_literal();
        build_literal(LIT_BIN, 66);
        send_literal();
    endtask

    task automatic test_random(input int n, input logic paced);
        int        stop_at;
        int        len;
        int        sel;
        t_lit_form form;
        pace_on = paced;
        stop_at = chars_sent + n;
        while (chars_sent < stop_at) begin
            sel = $urandom_range(0, 8);
            form = (sel < 8) ? t_lit_form'(sel / 2) : LIT_NOISE;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            build_literal(form, len);
            // Corrupt one character now and then.
            if ($urandom_range(0, 7) == 0)
                lit_chars[$urandom_range(0, lit_chars.size() - 1)] = 8'($urandom_range(0, 255));
            send_literal();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_chr = 8'd0;
        i_final_req = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LITTLE_ENDIAN;
        i_cfg_data = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        apply_mode(1'b1, 1'b1);
        test_wide_shifts();
        apply_mode(1'b0, 1'b1);
        test_random(80, 1'b1);
        apply_mode(1'b1, 1'b0);
        test_random(80, 1'b0);
        apply_mode(1'b0, 1'b0);
        test_random(80, 1'b1);
        apply_mode(1'b1, 1'b1);
        test_random(80, 1'b1);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_readings.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mrlp_pkg.sv
sv/mrlp_front.sv
sv/mrlp_queue.sv
sv/mrlp_back.sv
sv/multi_radix_literal_parser.sv
verif/tb_top.sv
